FILE: rtl/core/roulette_wheel_selector_defines.svh
// Assertion helpers for the roulette wheel selector.
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define RWS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rws assertion failed");

// Next-cycle implication.
`define RWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rws assertion failed");

`endif

FILE: rtl/core/rws_pkg.sv
package rws_pkg;

    localparam int MAX_POP  = 256;
    localparam int FIT_BITS = 32;
    localparam int RND_BITS = 16;
    localparam int SUM_BITS = 40;
    localparam int IDX_BITS = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
    localparam int CNT_BITS = $clog2(MAX_POP + 1);
    localparam int STS_BITS = 2;

    localparam int OUT_IDX_BITS = 8;
    localparam int OUT_CNT_BITS = 9;

    localparam int IN_RAW_BITS   = FIT_BITS + RND_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = OUT_IDX_BITS + OUT_CNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    localparam logic [STS_BITS-1:0] STS_OK    = 2'd0;
    localparam logic [STS_BITS-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_BITS-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        logic [SUM_BITS-1:0] wdata;
        logic                re;
        logic [IDX_BITS-1:0] raddr;
    } t_ram_req;

endpackage

FILE: rtl/core/rws_prefix_ram.sv
module rws_prefix_ram
    import rws_pkg::*;
(
    input  logic                i_clk,
    input  t_ram_req            i_req,
    output logic [SUM_BITS-1:0] o_rdata
);

    logic [SUM_BITS-1:0] r_mem [MAX_POP];
    logic [SUM_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/core/roulette_wheel_selector.sv
// Load beat: LOAD writes the prefix sum, EMIT registers the result, then the next beat is taken.
// Select beat: MUL scales the fraction, then ceil(log2(count+1)) probes of the prefix-sum RAM,
// each a PROBE (read) then a CMP (compare), then EMIT registers the result and the next beat
// is taken (no probes on an empty population). A stalled result holds the output register
// while the next beat is taken and processed.
// Sync active-low reset clears count, total, FSM and out valid; prefix RAM is not cleared.
module roulette_wheel_selector
    import rws_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,  // fitness_value, random_fraction
    input  logic [IN_USER_BITS-1:0]  i_s_axis_tuser,  // mode, start_new
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,  // selected_index, population_count
    output logic [STS_BITS-1:0]      o_m_axis_tuser   // status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [SUM_BITS-1:0] r_total, n_total;
    logic                r_m_valid, n_m_valid;

    logic                r_start, n_start;
    logic [FIT_BITS-1:0] r_fit, n_fit;
    logic [RND_BITS-1:0] r_frac, n_frac;
    logic [SUM_BITS-1:0] r_portion, n_portion;
    logic [CNT_BITS-1:0] r_lo, n_lo;
    logic [CNT_BITS-1:0] r_hi, n_hi;
    logic [CNT_BITS-1:0] r_mid, n_mid;
    logic [IDX_BITS-1:0] r_res_idx, n_res_idx;
    logic [STS_BITS-1:0] r_res_sts, n_res_sts;
    logic [IDX_BITS-1:0] r_m_idx, n_m_idx;
    logic [STS_BITS-1:0] r_m_sts, n_m_sts;
    logic [CNT_BITS-1:0] r_m_cnt, n_m_cnt;

    t_ram_req            w_req;
    logic [SUM_BITS-1:0] w_rdata;

    logic                     w_accept;
    logic [CNT_BITS:0]        w_sum_lh;
    logic [CNT_BITS-1:0]      w_mid;
    logic [CNT_BITS-1:0]      w_cnt_base;
    logic [SUM_BITS-1:0]      w_tot_base;
    logic [SUM_BITS:0]        w_add;
    logic [SUM_BITS-1:0]      w_sat;
    logic [RND_BITS+SUM_BITS-1:0] w_prod;

    rws_prefix_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_sum_lh   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum_lh[CNT_BITS:1];
    assign w_cnt_base = r_start ? '0 : r_count;
    assign w_tot_base = r_start ? '0 : r_total;
    assign w_add      = {1'b0, w_tot_base} + {{(SUM_BITS+1-FIT_BITS){1'b0}}, r_fit};
    assign w_sat      = w_add[SUM_BITS] ? {SUM_BITS{1'b1}} : w_add[SUM_BITS-1:0];
    assign w_prod     = {{SUM_BITS{1'b0}}, r_frac} * {{RND_BITS{1'b0}}, r_total};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_total   = r_total;
        n_m_valid = r_m_valid;
        n_start   = r_start;
        n_fit     = r_fit;
        n_frac    = r_frac;
        n_portion = r_portion;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_res_idx = r_res_idx;
        n_res_sts = r_res_sts;
        n_m_idx   = r_m_idx;
        n_m_sts   = r_m_sts;
        n_m_cnt   = r_m_cnt;
        w_req     = '0;

        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_start = i_s_axis_tuser[1];
                    n_fit   = i_s_axis_tdata[FIT_BITS-1:0];
                    n_frac  = i_s_axis_tdata[IN_RAW_BITS-1:FIT_BITS];
                    n_state = (i_s_axis_tuser[0] == MODE_SELECT) ? ST_MUL : ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_count = w_cnt_base;
                n_total = w_tot_base;
                if (w_cnt_base >= CNT_BITS'(MAX_POP)) begin
                    n_res_idx = '0;
                    n_res_sts = STS_FULL;
                end else begin
                    w_req.we    = 1'b1;
                    w_req.waddr = w_cnt_base[IDX_BITS-1:0];
                    w_req.wdata = w_sat;
                    n_total     = w_sat;
                    n_count     = w_cnt_base + 1'b1;
                    n_res_idx   = w_cnt_base[IDX_BITS-1:0];
                    n_res_sts   = STS_OK;
                end
                n_state = ST_EMIT;
            end
            ST_MUL: begin
                n_portion = w_prod[RND_BITS+SUM_BITS-1:RND_BITS];
                n_lo      = '0;
                n_hi      = r_count;
                if (r_count == '0) begin
                    n_res_idx = '0;
                    n_res_sts = STS_EMPTY;
                    n_state   = ST_EMIT;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = w_mid[IDX_BITS-1:0];
                    n_mid       = w_mid;
                    n_state     = ST_CMP;
                end else begin
                    n_res_idx = (r_lo == r_count) ? '0 : r_lo[IDX_BITS-1:0];
                    n_res_sts = STS_OK;
                    n_state   = ST_EMIT;
                end
            end
            ST_CMP: begin
                if (w_rdata > r_portion) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + 1'b1;
                end
                n_state = ST_PROBE;
            end
            ST_EMIT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_idx   = r_res_idx;
                    n_m_sts   = r_res_sts;
                    n_m_cnt   = r_count;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_total   <= n_total;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start   <= n_start;
        r_fit     <= n_fit;
        r_frac    <= n_frac;
        r_portion <= n_portion;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_res_idx <= n_res_idx;
        r_res_sts <= n_res_sts;
        r_m_idx   <= n_m_idx;
        r_m_sts   <= n_m_sts;
        r_m_cnt   <= n_m_cnt;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_sts;
    assign o_m_axis_tdata  = {{(OUT_DATA_BITS-OUT_RAW_BITS){1'b0}},
                              OUT_CNT_BITS'(r_m_cnt), OUT_IDX_BITS'(r_m_idx)};

endmodule

FILE: rtl/core/rws_checker.sv
`include "roulette_wheel_selector_defines.svh"

module rws_checker
    import rws_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input logic [STS_BITS-1:0]      o_m_axis_tuser
);

    logic [OUT_IDX_BITS-1:0]           w_idx;
    logic [OUT_CNT_BITS-1:0]           w_cnt;
    logic [STS_BITS+OUT_DATA_BITS-1:0] w_beat;
    logic                              w_stall;
    logic                              w_ok;
    logic                              w_empty;
    logic                              w_full;
    logic                              w_at_cap;

    assign w_idx    = o_m_axis_tdata[OUT_IDX_BITS-1:0];
    assign w_cnt    = o_m_axis_tdata[OUT_RAW_BITS-1:OUT_IDX_BITS];
    assign w_beat   = {o_m_axis_tuser, o_m_axis_tdata};
    assign w_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_ok     = o_m_axis_tvalid && (o_m_axis_tuser == STS_OK);
    assign w_empty  = o_m_axis_tvalid && (o_m_axis_tuser == STS_EMPTY);
    assign w_full   = o_m_axis_tvalid && (o_m_axis_tuser == STS_FULL);
    assign w_at_cap = (w_cnt == OUT_CNT_BITS'(MAX_POP));

    // stalled beat holds
    `RWS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, o_m_axis_tvalid && $stable(w_beat))
    `RWS_ASSERT_IMPLY(a_empty, i_clk, i_rst_n, w_empty, (w_idx == '0) && (w_cnt == '0))
    `RWS_ASSERT_IMPLY(a_full, i_clk, i_rst_n, w_full, (w_idx == '0) && w_at_cap)
    `RWS_ASSERT_IMPLY(a_ok_idx, i_clk, i_rst_n, w_ok, ({1'b0, w_idx} < w_cnt))
    `RWS_ASSERT_IMPLY(a_sts_code, i_clk, i_rst_n, o_m_axis_tvalid, w_ok || w_empty || w_full)

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (.*);
